// ===== src/l2bh_pkg.sv =====
`timescale 1ns / 1ps

package l2bh_pkg;

	// Golden-ratio seed that words a and b start from.
	localparam logic [31:0] GOLDEN_SEED = 32'h9E37_79B9;

	// Bytes per block and number of subtract-xor-shift steps in one mix.
	localparam int unsigned BLOCK_BYTES = 12;
	localparam int unsigned MIX_STEPS = 9;

	// Result queue depth; a power of two.
	localparam int unsigned OUT_FIFO_DEPTH = 16;

	// Shift distance of each mix step, in order.
	localparam logic [4:0] MIX_SHIFT [0:MIX_STEPS-1] = '{
		5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
	};

	typedef logic [31:0] word_t;

	// The three hash words.
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
	} mix_words_t;

	// Control carried along with the words through the mix pipeline.
	typedef struct packed {
		logic vld;  // slot holds an entry
		logic fb;   // block mix: the words go back to the hash state
		logic zero; // empty message: the result is zero
	} slot_ctl_t;

	// One step of the mix. Steps rotate over the target word a, b, c.
	function automatic mix_words_t mix_step(input mix_words_t w, input logic [3:0] step);
		mix_words_t r;
		r = w;
		case (step) inside
			4'd0, 4'd3, 4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> MIX_SHIFT[step]);
			4'd1, 4'd4, 4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << MIX_SHIFT[step]);
			default: r.c = (w.c - w.a - w.b) ^ (w.b >> MIX_SHIFT[step]);
		endcase
		return r;
	endfunction

endpackage

// ===== src/lookup2_byte_hash.sv =====
`timescale 1ns / 1ps
// A finishing item's hash passes the pipeline entry register, the mix stages and the result queue.
// Throughput: one byte per cycle while no tail mix waits and fewer than FIFO_DEPTH results are owed.
// A last byte that closes a block, or comes while that block's mix is under way, waits for that
// block's mix: its tail mix starts once the block mix has gone back to the hash state, and no
// next item is taken before the tail mix has started.
// Reset (arst_n low, asynchronous): hash words a, b to seed and c to zero, pipeline and queue empty.
module lookup2_byte_hash #(
	parameter int unsigned FIFO_DEPTH = l2bh_pkg::OUT_FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 empty_message,
	output logic                 out_valid,
	input  logic                 out_ready,
	output l2bh_pkg::word_t      hash_value
);
	import l2bh_pkg::*;

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [3:0] LAST_POS = 4'(BLOCK_BYTES - 1);

	// Hash state of the current message.
	mix_words_t  base_q;
	word_t       blk_a_q;
	word_t       blk_b_q;
	logic [23:0] pend_q;
	logic [3:0]  pos_q;
	word_t       len_q;
	logic        busy_q;
	logic        drop_q;
	logic        tail_wait_q;
	mix_words_t  tail_q;

	// Mix pipeline.
	mix_words_t stage_w_q   [0:MIX_STEPS];
	slot_ctl_t  stage_ctl_q [0:MIX_STEPS];

	// Result queue and credit count.
	word_t            fifo_mem [0:FIFO_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fifo_cnt_q;
	logic [CNT_W-1:0] credit_q;

	logic        in_fire;
	logic        out_fire;
	logic        fb_exit;
	logic        res_exit;
	logic        blk_done;
	word_t       blk_a_nx;
	word_t       blk_b_nx;
	logic [23:0] pend_nx;
	word_t       len_nx;
	word_t       tail_add_c;
	logic        tail_issue;
	mix_words_t  issue_w;
	slot_ctl_t   issue_ctl;

	assign in_ready = !tail_wait_q && (credit_q < CNT_W'(FIFO_DEPTH));
	assign in_fire  = in_valid && in_ready;
	assign out_valid  = (fifo_cnt_q != '0);
	assign out_fire   = out_valid && out_ready;
	assign hash_value = fifo_mem[rd_ptr_q];
	assign fb_exit  = stage_ctl_q[MIX_STEPS].vld && stage_ctl_q[MIX_STEPS].fb;
	assign res_exit = stage_ctl_q[MIX_STEPS].vld && !stage_ctl_q[MIX_STEPS].fb;
	assign tail_issue = tail_wait_q && !busy_q;

	// Place the incoming byte into the block being assembled.
	always_comb begin
		blk_a_nx = blk_a_q;
		blk_b_nx = blk_b_q;
		pend_nx  = pend_q;
		blk_done = 1'b0;
		case (pos_q) inside
			[4'd0:4'd3]: begin
				blk_a_nx = blk_a_q | (word_t'(data_byte) << {pos_q[1:0], 3'b000});
			end
			[4'd4:4'd7]: begin
				blk_b_nx = blk_b_q | (word_t'(data_byte) << {pos_q[1:0], 3'b000});
			end
			[4'd8:4'd10]: begin
				pend_nx = pend_q | (24'(data_byte) << {pos_q[1:0], 3'b000});
			end
			default: begin
				blk_done = 1'b1;
				blk_a_nx = '0;
				blk_b_nx = '0;
				pend_nx  = '0;
			end
		endcase
		len_nx     = len_q + 32'd1;
		tail_add_c = len_nx + {pend_nx, 8'h00};
	end

	// Choose what enters the mix pipeline this cycle.
	always_comb begin
		issue_w   = '0;
		issue_ctl = '0;
		if (tail_issue) begin
			issue_ctl.vld = 1'b1;
			issue_w.a = base_q.a + tail_q.a;
			issue_w.b = base_q.b + tail_q.b;
			issue_w.c = base_q.c + tail_q.c;
		end else if (in_fire) begin
			if (empty_message) begin
				issue_ctl.vld  = 1'b1;
				issue_ctl.zero = 1'b1;
			end else if (blk_done) begin
				issue_ctl.vld = 1'b1;
				issue_ctl.fb  = 1'b1;
				issue_w.a = base_q.a + blk_a_q;
				issue_w.b = base_q.b + blk_b_q;
				issue_w.c = base_q.c + {data_byte, pend_q};
			end else if (last_byte && !busy_q) begin
				issue_ctl.vld = 1'b1;
				issue_w.a = base_q.a + blk_a_nx;
				issue_w.b = base_q.b + blk_b_nx;
				issue_w.c = base_q.c + tail_add_c;
			end
		end
	end

	// Hash state, block assembly and tail hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '{a: GOLDEN_SEED, b: GOLDEN_SEED, c: '0};
			blk_a_q     <= '0;
			blk_b_q     <= '0;
			pend_q      <= '0;
			pos_q       <= '0;
			len_q       <= '0;
			busy_q      <= 1'b0;
			drop_q      <= 1'b0;
			tail_wait_q <= 1'b0;
			tail_q      <= '0;
		end else begin
			// A block mix returns: it becomes the new state unless its message was dropped.
			if (fb_exit) begin
				busy_q <= 1'b0;
				if (drop_q) begin
					drop_q <= 1'b0;
				end else begin
					base_q <= stage_w_q[MIX_STEPS];
				end
			end
			// A waiting tail starts its mix; the state is free for the next message.
			if (tail_issue) begin
				tail_wait_q <= 1'b0;
				base_q      <= '{a: GOLDEN_SEED, b: GOLDEN_SEED, c: '0};
			end
			if (in_fire) begin
				if (empty_message) begin
					base_q  <= '{a: GOLDEN_SEED, b: GOLDEN_SEED, c: '0};
					blk_a_q <= '0;
					blk_b_q <= '0;
					pend_q  <= '0;
					pos_q   <= '0;
					len_q   <= '0;
					busy_q  <= 1'b0;
					if (busy_q && !fb_exit) begin
						drop_q <= 1'b1;
					end
				end else begin
					if (blk_done) begin
						busy_q <= 1'b1;
					end
					if (last_byte) begin
						blk_a_q <= '0;
						blk_b_q <= '0;
						pend_q  <= '0;
						pos_q   <= '0;
						len_q   <= '0;
						if (!blk_done && !busy_q) begin
							base_q <= '{a: GOLDEN_SEED, b: GOLDEN_SEED, c: '0};
						end else begin
							tail_wait_q <= 1'b1;
							tail_q      <= '{a: blk_a_nx, b: blk_b_nx, c: tail_add_c};
						end
					end else begin
						blk_a_q <= blk_a_nx;
						blk_b_q <= blk_b_nx;
						pend_q  <= pend_nx;
						pos_q   <= (pos_q == LAST_POS) ? 4'd0 : pos_q + 4'd1;
						len_q   <= len_nx;
					end
				end
			end
		end
	end

	// Pipeline entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_ctl_q[0] <= '0;
		end else begin
			stage_ctl_q[0] <= issue_ctl;
		end
	end

	always_ff @(posedge clk) begin
		stage_w_q[0] <= issue_w;
	end

	// One mix step per stage.
	for (genvar k = 0; k < MIX_STEPS; k++) begin : g_mix
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_ctl_q[k+1] <= '0;
			end else begin
				stage_ctl_q[k+1] <= stage_ctl_q[k];
			end
		end

		always_ff @(posedge clk) begin
			stage_w_q[k+1] <= mix_step(stage_w_q[k], 4'(k));
		end
	end

	// Result queue; credits keep it from overflowing.
	always_ff @(posedge clk) begin
		if (res_exit) begin
			fifo_mem[wr_ptr_q] <= stage_ctl_q[MIX_STEPS].zero ? '0 : stage_w_q[MIX_STEPS].c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			credit_q   <= '0;
		end else begin
			if (res_exit) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + CNT_W'(res_exit) - CNT_W'(out_fire);
			credit_q   <= credit_q + CNT_W'(in_fire && (empty_message || last_byte))
				- CNT_W'(out_fire);
		end
	end

endmodule

// ===== src/l2bh_checker.sv =====
`timescale 1ns / 1ps

module l2bh_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [7:0]           data_byte,
	input logic                 last_byte,
	input logic                 empty_message,
	input logic                 out_valid,
	input logic                 out_ready,
	input l2bh_pkg::word_t      hash_value
);
	import l2bh_pkg::*;

	logic       in_fire;
	logic       out_fire;
	logic       res_in;
	logic [7:0] pending_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign res_in   = in_fire && (empty_message || last_byte);

	// Results owed: finishing items accepted minus results taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 8'(res_in) - 8'(out_fire);
		end
	end

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hash_value))
		else $error("result changed while stalled");

	// No result appears that no finishing item asked for.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("result offered with no finished message outstanding");

	// An empty message with nothing ahead of it yields zero after the pipeline.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && empty_message && pending_q == 8'd0
		|-> ##11 (out_valid && hash_value == 32'd0))
		else $error("empty message did not give a zero hash");

endmodule

bind lookup2_byte_hash l2bh_checker u_l2bh_checker (.*);
